// File: hdl/pgw_pkg.sv
// Shared types and constants for the page table map walker.
`timescale 1ns / 1ps
`default_nettype none
package pgw_pkg;

  localparam int unsigned VPN_W   = 36;
  localparam int unsigned PFN_W   = 40;
  localparam int unsigned CNT_W   = 21;
  localparam int unsigned TIU_W   = 7;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned IDX_W   = 9;

  // largest page count one request may map
  localparam logic [CNT_W-1:0] MAX_COUNT = 21'h10_0000;

  // low bits of an intermediate entry: present, writable, user
  localparam logic [11:0] TABLE_FLAGS = 12'h007;

  // walk levels that hold table pointers, top first
  localparam logic [1:0] LVL_L3 = 2'd3;
  localparam logic [1:0] LVL_L2 = 2'd2;
  localparam logic [1:0] LVL_L1 = 2'd1;

  typedef struct packed {
    logic [VPN_W-1:0] virt_page_start;
    logic [PFN_W-1:0] phys_page_start;
    logic [CNT_W-1:0] page_count;
    logic             attr_present;
    logic             attr_writable;
    logic             attr_user;
    logic             attr_global;
    logic             attr_nx;
  } pgw_req_t;

  typedef struct packed {
    logic               status;
    logic [CNT_W-1:0]   pages_mapped;
    logic [TIU_W-1:0]   tables_in_use;
    logic [ENTRY_W-1:0] last_leaf_entry;
  } pgw_rsp_t;

  // leaf entry: frame address plus selected attribute bits
  function automatic logic [ENTRY_W-1:0] leaf_entry(input logic [PFN_W-1:0] pfn,
                                                   input pgw_req_t        attr);
    leaf_entry = {attr.attr_nx, 11'b0, pfn, 3'b0, attr.attr_global, 5'b0,
                  attr.attr_user, attr.attr_writable, attr.attr_present};
  endfunction

  // intermediate entry pointing at a table frame
  function automatic logic [ENTRY_W-1:0] table_entry(input logic [PFN_W-1:0] frame);
    table_entry = {12'b0, frame, TABLE_FLAGS};
  endfunction

endpackage
`default_nettype wire

// File: hdl/page_table_map_walker.sv
// Top level of the page table map walker: config register, result register.
//
// Builds four-level x86-64 style page tables in an internal table store.
// Config: cfg_we_i/cfg_wdata_i write the root frame number into a register;
//   write it only while no request is in flight.
// Request channel (req_valid_i/req_ready_o, req_i): one mapping request,
//   taken only when the walker is idle; one request is worked at a time.
// Result channel (rsp_valid_o/rsp_ready_i, rsp_o): one result per request,
//   held in an output register so the walker may take the next request
//   while the result waits for the receiver.
// Walk: each page takes three read-then-check steps through the single-port
//   table RAM, a read step and then a check step, followed by a leaf write.
//   A request that runs out of tables ends early.
// Reset: the table store is swept to zero, one entry per cycle, over all
//   MAX_TABLES*512 entries (32768 at the default); req_ready_o stays low
//   meanwhile. The allocator restarts at one table (the root).
// Stall: if the receiver holds rsp_ready_i low, a finished result stays in
//   the output register and a second finished result waits in the walker.
`timescale 1ns / 1ps
`default_nettype none
module page_table_map_walker
  import pgw_pkg::*;
#(
  parameter int unsigned MAX_TABLES = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [PFN_W-1:0] cfg_wdata_i,
  input  wire logic             req_valid_i,
  output logic                  req_ready_o,
  input  wire pgw_req_t         req_i,
  output logic                  rsp_valid_o,
  input  wire logic             rsp_ready_i,
  output pgw_rsp_t              rsp_o
);

  localparam int unsigned SW    = $clog2(MAX_TABLES);
  localparam int unsigned AW    = SW + IDX_W;
  localparam int unsigned DEPTH = MAX_TABLES * (2 ** IDX_W);

  logic [PFN_W-1:0]   root_q;
  logic               res_valid;
  logic               res_ready;
  pgw_rsp_t           res;
  logic               out_valid_q;
  pgw_rsp_t           out_q;

  logic               mem_we;
  logic               mem_re;
  logic [AW-1:0]      mem_addr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;

  // root frame register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q <= '0;
    end else if (cfg_we_i) begin
      root_q <= cfg_wdata_i;
    end
  end

  pgw_walker #(
    .MAX_TABLES (MAX_TABLES),
    .SW         (SW),
    .AW         (AW)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .root_i      (root_q),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  pgw_table_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // output register: refills in the cycle the receiver drains it
  assign res_ready = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

endmodule
`default_nettype wire

// File: hdl/pgw_table_ram.sv
// Table store: single-port synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module pgw_table_ram #(
  parameter int unsigned DEPTH = 32768,
  parameter int unsigned AW    = 15,
  parameter int unsigned DW    = 64
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] addr_i,
  input  wire logic [DW-1:0] wdata_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [0:DEPTH-1];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// File: hdl/pgw_walker.sv
// Walk sequencer: clears the table store, walks and fills tables page by page.
`timescale 1ns / 1ps
`default_nettype none
module pgw_walker
  import pgw_pkg::*;
#(
  parameter int unsigned MAX_TABLES = 64,
  parameter int unsigned SW         = $clog2(MAX_TABLES),
  parameter int unsigned AW         = SW + IDX_W
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [PFN_W-1:0]   root_i,
  input  wire logic               req_valid_i,
  output logic                    req_ready_o,
  input  wire pgw_req_t           req_i,
  output logic                    res_valid_o,
  input  wire logic               res_ready_i,
  output pgw_rsp_t                res_o,
  output logic                    mem_we_o,
  output logic                    mem_re_o,
  output logic [AW-1:0]           mem_addr_o,
  output logic [ENTRY_W-1:0]      mem_wdata_o,
  input  wire logic [ENTRY_W-1:0] mem_rdata_i
);

  localparam int unsigned FW    = $clog2(MAX_TABLES + 1);
  localparam int unsigned DEPTH = MAX_TABLES * (2 ** IDX_W);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_LEAF  = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [FW-1:0]      frames_q, frames_d;
  logic [1:0]         lvl_q, lvl_d;
  logic [SW-1:0]      slot_q, slot_d;
  logic [VPN_W-1:0]   vpn_q, vpn_d;
  logic [PFN_W-1:0]   pfn_q, pfn_d;
  logic [CNT_W-1:0]   remain_q, remain_d;
  logic [CNT_W-1:0]   done_q, done_d;
  logic               status_q, status_d;
  logic [ENTRY_W-1:0] last_q, last_d;
  pgw_req_t           attr_q, attr_d;

  logic [IDX_W-1:0]   idx;
  logic [CNT_W-1:0]   count_clamped;
  logic [PFN_W-1:0]   rd_frame;
  logic [PFN_W-1:0]   rd_slot;
  logic [PFN_W-1:0]   new_frame;
  logic               hit;
  logic               full;
  logic [ENTRY_W-1:0] leaf;
  logic [FW+TIU_W-1:0] frames_ext;

  always_comb begin
    case (lvl_q)
      LVL_L3:  idx = vpn_q[3*IDX_W +: IDX_W];
      LVL_L2:  idx = vpn_q[2*IDX_W +: IDX_W];
      default: idx = vpn_q[IDX_W +: IDX_W];
    endcase
  end

  assign count_clamped = (req_i.page_count > MAX_COUNT) ? MAX_COUNT : req_i.page_count;

  // a present entry counts only if it points into an allocated table
  assign rd_frame  = mem_rdata_i[12 +: PFN_W];
  assign rd_slot   = rd_frame - root_i;
  assign hit       = mem_rdata_i[0] && (rd_slot < PFN_W'(frames_q));
  assign full      = (frames_q == FW'(MAX_TABLES));
  assign new_frame = root_i + PFN_W'(frames_q);
  assign leaf      = leaf_entry(pfn_q, attr_q);

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    frames_d    = frames_q;
    lvl_d       = lvl_q;
    slot_d      = slot_q;
    vpn_d       = vpn_q;
    pfn_d       = pfn_q;
    remain_d    = remain_q;
    done_d      = done_q;
    status_d    = status_q;
    last_d      = last_q;
    attr_d      = attr_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = {slot_q, idx};
    mem_wdata_o = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we_o   = 1'b1;
        mem_addr_o = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid_i) begin
          vpn_d    = req_i.virt_page_start;
          pfn_d    = req_i.phys_page_start;
          remain_d = count_clamped;
          done_d   = '0;
          status_d = 1'b0;
          last_d   = '0;
          attr_d   = req_i;
          lvl_d    = LVL_L3;
          slot_d   = '0;
          state_d  = (count_clamped == '0) ? ST_DONE : ST_READ;
        end
      end
      ST_READ: begin
        mem_re_o = 1'b1;
        state_d  = ST_CHECK;
      end
      ST_CHECK: begin
        if (hit) begin
          slot_d = rd_slot[SW-1:0];
        end else if (full) begin
          status_d = 1'b1;
          state_d  = ST_DONE;
        end else begin
          mem_we_o    = 1'b1;
          mem_wdata_o = table_entry(new_frame);
          frames_d    = frames_q + 1'b1;
          slot_d      = frames_q[SW-1:0];
        end
        if (hit || !full) begin
          if (lvl_q == LVL_L1) begin
            state_d = ST_LEAF;
          end else begin
            lvl_d   = lvl_q - 1'b1;
            state_d = ST_READ;
          end
        end
      end
      ST_LEAF: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = {slot_q, vpn_q[IDX_W-1:0]};
        mem_wdata_o = leaf;
        last_d      = leaf;
        done_d      = done_q + 1'b1;
        remain_d    = remain_q - 1'b1;
        vpn_d       = vpn_q + 1'b1;
        pfn_d       = pfn_q + 1'b1;
        lvl_d       = LVL_L3;
        slot_d      = '0;
        state_d     = (remain_q == CNT_W'(1)) ? ST_DONE : ST_READ;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      frames_q <= FW'(1);
      lvl_q    <= LVL_L3;
      slot_q   <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      frames_q <= frames_d;
      lvl_q    <= lvl_d;
      slot_q   <= slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vpn_q    <= vpn_d;
    pfn_q    <= pfn_d;
    remain_q <= remain_d;
    done_q   <= done_d;
    status_q <= status_d;
    last_q   <= last_d;
    attr_q   <= attr_d;
  end

  assign frames_ext  = {{TIU_W{1'b0}}, frames_q};
  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = '{status:          status_q,
                         pages_mapped:    done_q,
                         tables_in_use:   frames_ext[TIU_W-1:0],
                         last_leaf_entry: last_q};

endmodule
`default_nettype wire

// File: hdl/pgw_checker.sv
// Port-level checks for the page table map walker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pgw_checker
  import pgw_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     req_valid_i,
  input wire logic     req_ready_o,
  input wire logic     rsp_valid_o,
  input wire logic     rsp_ready_i,
  input wire pgw_rsp_t rsp_o
);

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> $stable(rsp_o))
    else $error("result changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("second request taken while walking");

  a_empty_leaf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && (rsp_o.pages_mapped == '0) |-> (rsp_o.last_leaf_entry == '0))
    else $error("leaf entry reported with no page mapped");

endmodule

bind page_table_map_walker pgw_checker u_pgw_checker (.*);
`default_nettype wire
